// File: design/lqr_gain_polynomial_schedule_defines.svh
// Assertion macros for the checker file of the leg-length gain scheduler
`ifndef LQR_GAIN_POLYNOMIAL_SCHEDULE_DEFINES_SVH
`define LQR_GAIN_POLYNOMIAL_SCHEDULE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define LGPS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define LGPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/lgps_pkg.sv
// Package: types, codes and coefficient ROM of the leg-length gain scheduler
package lgps_pkg;

	localparam int LEN_W      = 16;
	localparam int X_W        = 16;
	localparam int ACC_W      = 32;
	localparam int GAIN_W     = 25;
	localparam int NUM_W      = 20;
	localparam int MUL_A_W    = 32;
	localparam int MUL_B_W    = 22;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int QUO_W      = 18;
	localparam int ROW_W      = 2;
	localparam int COL_W      = 4;
	localparam int CNT_W      = 4;
	localparam int MAX_RESULTS = 12;
	localparam int ROM_ROWS   = 2;
	localparam int ROM_COLS   = 6;

	// Q0.16 value of 0.25 m
	localparam logic [LEN_W:0] CENTER_LEN = 17'd16384;
	// ceil(2^22 / 3), exact floor(n / 3) for n < 2^21
	localparam logic signed [MUL_B_W-1:0] RECIP3 = 22'sd1398102;
	localparam int RECIP3_SHIFT = 22;
	localparam logic signed [PROD_W-1:0] ROUND_HALF = 54'sd16384;
	localparam int HORNER_SHIFT = 15;
	localparam logic signed [ACC_W-1:0] GAIN_HI = 32'sd16777215;
	localparam logic signed [ACC_W-1:0] GAIN_LO = -32'sd16777216;
	localparam logic [QUO_W-1:0] X_POS_LIM = 18'd32767;
	localparam logic [QUO_W-1:0] X_NEG_LIM = 18'd32768;
	localparam logic signed [X_W-1:0] X_MAX = 16'sh7fff;
	localparam logic signed [X_W-1:0] X_MIN = 16'sh8000;

	localparam logic [LEN_W-1:0] MIN_LEG_RST = 16'd9918;
	localparam logic [LEN_W-1:0] MAX_LEG_RST = 16'd19888;

	localparam logic [1:0] TAP_C0    = 2'd0;
	localparam logic [1:0] TAP_FIRST = 2'd1;
	localparam logic [1:0] TAP_LAST  = 2'd3;

	typedef enum logic {
		CFG_MIN_LEG = 1'b0,
		CFG_MAX_LEG = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_NMUL,
		ST_NFIN,
		ST_MUL,
		ST_ADD,
		ST_LOAD
	} lgps_state_t;

	typedef struct packed {
		logic             ld_len;
		logic             prep;
		logic             mul_norm;
		logic             mul_en;
		logic             norm_fin;
		logic             acc_sum;
		logic             acc_coef;
		logic             emit;
		logic [ROW_W-1:0] coef_row;
		logic [COL_W-1:0] coef_col;
		logic [1:0]       coef_tap;
	} lgps_ctrl_t;

	// cubic coefficients c0..c3 per gain, signed Q9.16
	localparam logic signed [ACC_W-1:0] COEF_ROM [ROM_ROWS][ROM_COLS][4] = '{
		'{
			'{-32'sd65928, 32'sd90026, -32'sd244330, -32'sd1237405},
			'{32'sd314, 32'sd855, -32'sd69594, -32'sd142843},
			'{-32'sd30444, 32'sd31829, -32'sd30363, -32'sd248284},
			'{-32'sd21721, 32'sd22489, -32'sd33181, -32'sd223870},
			'{-32'sd18668, 32'sd114718, -32'sd202640, 32'sd160726},
			'{-32'sd3594, 32'sd12355, -32'sd24414, 32'sd18885}
		},
		'{
			'{32'sd5031, 32'sd715065, -32'sd1613539, 32'sd2191441},
			'{32'sd19324, 32'sd20016, -32'sd98050, 32'sd313259},
			'{-32'sd79865, 32'sd382702, -32'sd741343, 32'sd946711},
			'{-32'sd88859, 32'sd312022, -32'sd587967, 32'sd769990},
			'{32'sd623076, -32'sd650507, 32'sd553903, 32'sd8768386},
			'{32'sd67662, -32'sd63238, 32'sd45881, 32'sd293836}
		}
	};

	// entries outside the stored matrix read as zero
	function automatic logic signed [ACC_W-1:0] coef_f(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col, input logic [1:0] tap);
		logic signed [ACC_W-1:0] c;
		c = '0;
		if (row < ROW_W'(ROM_ROWS) && col < COL_W'(ROM_COLS)) begin
			c = COEF_ROM[row[0]][col[2:0]][tap];
		end
		return c;
	endfunction

endpackage

// File: design/lgps_if.sv
// Valid/ready channel interfaces for leg-length requests and gain results
interface lgps_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] len_sample;

	modport source (output valid, output len_sample, input ready);
	modport sink (input valid, input len_sample, output ready);
endinterface

interface lgps_out_if;
	logic               valid;
	logic               ready;
	logic               actuator_index;
	logic [2:0]         state_index;
	logic signed [24:0] gain_value;
	logic               last_gain;

	modport source (output valid, output actuator_index, output state_index,
		output gain_value, output last_gain, input ready);
	modport sink (input valid, input actuator_index, input state_index,
		input gain_value, input last_gain, output ready);
endinterface

// File: design/lqr_gain_polynomial_schedule.sv
// Top level: leg-length gain scheduler, cubic gain polynomials by Horner's rule
//
// in_ch carries one leg-length request (unsigned Q0.16 m). The sample is clamped
// to [min_leg_length, max_leg_length], normalized to x in signed Q1.15, and
// twelve cubic gains are evaluated on one shared 32x22 multiplier: three
// multiply/accumulate pairs per gain (states MUL and ADD), and the LOAD state
// between gains to load the leading coefficient of the next one.
// out_ch delivers one result per gain, actuator-major, with the row and
// column index, the gain in signed Q9.16 (saturated) and last_gain on the
// final one.
// After the request is taken, the PREP, NMUL and NFIN states normalize x and
// the gains follow; in_ch.ready is high only when idle, so a new request is
// taken only after the final gain has entered the output register.
// A single output register holds each result; while out_ch stalls, the
// sequencer waits on the finished gain and resumes when the register frees.
// Configuration: cfg_we with cfg_index 0 (min) or 1 (max), written while idle.
// Reset (arst_n low) returns to idle, empties the output register and loads
// the limits 9918 and 19888.
module lqr_gain_polynomial_schedule #(
	parameter int GAIN_ROWS = 2,
	parameter int GAIN_COLS = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  lgps_pkg::cfg_idx_t cfg_index,
	input  logic [15:0]        cfg_data,
	lgps_in_if.sink            in_ch,
	lgps_out_if.source         out_ch
);
	import lgps_pkg::*;

	lgps_ctrl_t ctl;

	lgps_ctrl #(
		.GAIN_ROWS (GAIN_ROWS),
		.GAIN_COLS (GAIN_COLS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_ch.valid),
		.in_ready       (in_ch.ready),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.actuator_index (out_ch.actuator_index),
		.state_index    (out_ch.state_index),
		.last_gain      (out_ch.last_gain),
		.ctl            (ctl)
	);

	lgps_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.len_sample (in_ch.len_sample),
		.ctl        (ctl),
		.gain_value (out_ch.gain_value)
	);

endmodule

// File: design/lgps_datapath.sv
// Datapath: limit registers, clamp, shared multiplier, normalize and Horner accumulate
module lgps_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  lgps_pkg::cfg_idx_t        cfg_index,
	input  logic [15:0]               cfg_data,
	input  logic [15:0]               len_sample,
	input  lgps_pkg::lgps_ctrl_t      ctl,
	output logic signed [24:0]        gain_value
);
	import lgps_pkg::*;

	logic [LEN_W-1:0]          min_leg_q;
	logic [LEN_W-1:0]          max_leg_q;
	logic [LEN_W-1:0]          len_lo;
	logic [LEN_W-1:0]          len_cl;
	logic [LEN_W-1:0]          len_q;
	logic signed [LEN_W:0]     dlt;
	logic [LEN_W:0]            dlt_abs;
	logic [NUM_W-1:0]          num;
	logic [NUM_W-1:0]          num_q;
	logic                      neg_q;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_q;
	logic [QUO_W-1:0]          quo;
	logic [QUO_W-1:0]          quo_neg;
	logic signed [X_W-1:0]     x_nx;
	logic signed [X_W-1:0]     x_q;
	logic signed [PROD_W-1:0]  rnd;
	logic signed [PROD_W-1:0]  rnd_sh;
	logic signed [ACC_W-1:0]   coef;
	logic signed [ACC_W-1:0]   sum;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [GAIN_W-1:0]  gain_sat;
	logic signed [GAIN_W-1:0]  gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_leg_q <= MIN_LEG_RST;
			max_leg_q <= MAX_LEG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_LEG: min_leg_q <= cfg_data;
				CFG_MAX_LEG: max_leg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// lower bound first, then upper bound
	assign len_lo = (len_sample < min_leg_q) ? min_leg_q : len_sample;
	assign len_cl = (len_lo > max_leg_q) ? max_leg_q : len_lo;

	// |10*d| + 1, rounded quotient by 3 follows
	assign dlt     = $signed({1'b0, len_q} - CENTER_LEN);
	assign dlt_abs = dlt[LEN_W] ? (LEN_W+1)'(-dlt) : dlt;
	assign num     = NUM_W'({dlt_abs, 3'b000}) + NUM_W'({dlt_abs, 1'b0}) + NUM_W'(1);

	assign mul_a = ctl.mul_norm ? $signed({{(MUL_A_W-NUM_W){1'b0}}, num_q}) : acc_q;
	assign mul_b = ctl.mul_norm ? RECIP3 : MUL_B_W'(x_q);

	assign quo     = prod_q[RECIP3_SHIFT +: QUO_W];
	assign quo_neg = QUO_W'(-quo);
	always_comb begin
		if (neg_q) begin
			x_nx = (quo > X_NEG_LIM) ? X_MIN : $signed(quo_neg[X_W-1:0]);
		end else begin
			x_nx = (quo > X_POS_LIM) ? X_MAX : $signed(quo[X_W-1:0]);
		end
	end

	assign coef   = coef_f(ctl.coef_row, ctl.coef_col, ctl.coef_tap);
	assign rnd    = prod_q + ROUND_HALF;
	assign rnd_sh = rnd >>> HORNER_SHIFT;
	assign sum    = $signed(rnd_sh[ACC_W-1:0]) + coef;

	always_comb begin
		if (sum > GAIN_HI) begin
			gain_sat = GAIN_HI[GAIN_W-1:0];
		end else if (sum < GAIN_LO) begin
			gain_sat = GAIN_LO[GAIN_W-1:0];
		end else begin
			gain_sat = sum[GAIN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_len) begin
			len_q <= len_cl;
		end
		if (ctl.prep) begin
			num_q <= num;
			neg_q <= dlt[LEN_W];
		end
		if (ctl.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (ctl.norm_fin) begin
			x_q <= x_nx;
		end
		if (ctl.acc_coef) begin
			acc_q <= coef;
		end else if (ctl.acc_sum) begin
			acc_q <= sum;
		end
		if (ctl.emit) begin
			gain_q <= gain_sat;
		end
	end

	assign gain_value = gain_q;

endmodule

// File: design/lgps_ctrl.sv
// Sequencer: state machine, gain and tap counters, result register control
module lgps_ctrl #(
	parameter int GAIN_ROWS = 2,
	parameter int GAIN_COLS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 actuator_index,
	output logic [2:0]           state_index,
	output logic                 last_gain,
	output lgps_pkg::lgps_ctrl_t ctl
);
	import lgps_pkg::*;

	localparam int RW = (GAIN_ROWS > 1) ? $clog2(GAIN_ROWS) : 1;
	localparam int CW = (GAIN_COLS > 1) ? $clog2(GAIN_COLS) : 1;
	localparam int PRODUCT = GAIN_ROWS * GAIN_COLS;
	localparam int TOTAL = (PRODUCT > MAX_RESULTS) ? MAX_RESULTS : PRODUCT;

	lgps_state_t      state_q;
	lgps_state_t      state_d;
	logic [1:0]       tap_q;
	logic [RW-1:0]    row_q;
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_nx;
	logic [CW-1:0]    col_nx;
	logic [CNT_W-1:0] cnt_q;
	logic             last;
	logic             slot_free;
	logic             out_valid_q;
	logic             out_act_q;
	logic [2:0]       out_st_q;
	logic             out_last_q;

	assign last      = (cnt_q == CNT_W'(TOTAL - 1));
	assign slot_free = !out_valid_q || out_ready;
	assign col_nx    = (col_q == CW'(GAIN_COLS - 1)) ? '0 : CW'(col_q + 1'b1);
	assign row_nx    = (col_q == CW'(GAIN_COLS - 1)) ? RW'(row_q + 1'b1) : row_q;

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		ctl          = '0;
		ctl.coef_row = ROW_W'(row_q);
		ctl.coef_col = COL_W'(col_q);
		ctl.coef_tap = TAP_C0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.ld_len = 1'b1;
					state_d    = ST_PREP;
				end
			end
			ST_PREP: begin
				ctl.prep = 1'b1;
				state_d  = ST_NMUL;
			end
			ST_NMUL: begin
				ctl.mul_norm = 1'b1;
				ctl.mul_en   = 1'b1;
				state_d      = ST_NFIN;
			end
			ST_NFIN: begin
				ctl.norm_fin = 1'b1;
				ctl.acc_coef = 1'b1;
				state_d      = ST_MUL;
			end
			ST_MUL: begin
				ctl.mul_en = 1'b1;
				state_d    = ST_ADD;
			end
			ST_ADD: begin
				if (tap_q != TAP_LAST) begin
					ctl.acc_sum  = 1'b1;
					ctl.coef_tap = tap_q;
					state_d      = ST_MUL;
				end else if (slot_free) begin
					ctl.emit     = 1'b1;
					ctl.coef_tap = TAP_LAST;
					state_d      = last ? ST_IDLE : ST_LOAD;
				end
			end
			// c0 of the next gain
			ST_LOAD: begin
				ctl.acc_coef = 1'b1;
				state_d      = ST_MUL;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tap_q       <= TAP_C0;
			row_q       <= '0;
			col_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_act_q   <= 1'b0;
			out_st_q    <= '0;
			out_last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.ld_len) begin
				row_q <= '0;
				col_q <= '0;
				cnt_q <= '0;
			end
			if (ctl.norm_fin) begin
				tap_q <= TAP_FIRST;
			end
			if (ctl.acc_sum) begin
				tap_q <= tap_q + 2'd1;
			end
			if (ctl.emit) begin
				tap_q       <= TAP_FIRST;
				row_q       <= row_nx;
				col_q       <= col_nx;
				cnt_q       <= cnt_q + 1'b1;
				out_valid_q <= 1'b1;
				out_act_q   <= 1'(row_q);
				out_st_q    <= 3'(col_q);
				out_last_q  <= last;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign actuator_index = out_act_q;
	assign state_index    = out_st_q;
	assign last_gain      = out_last_q;

endmodule

// File: design/lgps_checker.sv
// Port-level checker for the leg-length gain scheduler, bound to the top level
`include "lqr_gain_polynomial_schedule_defines.svh"

module lgps_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               actuator_index,
	input logic [2:0]         state_index,
	input logic signed [24:0] gain_value,
	input logic               last_gain
);

	`LGPS_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready ##1 !in_ready, "request taken too soon after previous")

	`LGPS_ASSERT_IMPL(a_idle_after_last, $rose(in_ready), out_valid && last_gain, "idle without final gain")

	`LGPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(gain_value) && $stable(state_index) && $stable(actuator_index) && $stable(last_gain), "stalled result changed")

endmodule

bind lqr_gain_polynomial_schedule lgps_checker u_lgps_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.actuator_index (out_ch.actuator_index),
	.state_index    (out_ch.state_index),
	.gain_value     (out_ch.gain_value),
	.last_gain      (out_ch.last_gain)
);

// File: bench/lqr_gain_polynomial_schedule_tb.sv
// Self-checking testbench for the leg-length gain scheduler: clamping, normalization, cubic gains

typedef struct {
	bit              actuator;
	bit [2:0]        state_col;
	bit signed [24:0] gain;
	bit              last;
} gain_entry_t;

localparam int GAIN_COEF [2][6][4] = '{
	'{
		'{-65928, 90026, -244330, -1237405},
		'{314, 855, -69594, -142843},
		'{-30444, 31829, -30363, -248284},
		'{-21721, 22489, -33181, -223870},
		'{-18668, 114718, -202640, 160726},
		'{-3594, 12355, -24414, 18885}
	},
	'{
		'{5031, 715065, -1613539, 2191441},
		'{19324, 20016, -98050, 313259},
		'{-79865, 382702, -741343, 946711},
		'{-88859, 312022, -587967, 769990},
		'{623076, -650507, 553903, 8768386},
		'{67662, -63238, 45881, 293836}
	}
};

class gain_schedule_checker;
	bit [15:0]   min_len;
	bit [15:0]   max_len;
	gain_entry_t pending_gains[$];
	int          mismatches;
	int          requests;
	int          gains_seen;

	function new();
		min_len = 16'd9918;
		max_len = 16'd19888;
		mismatches = 0;
		requests = 0;
		gains_seen = 0;
	endfunction

	function void set_limits(bit [15:0] lo, bit [15:0] hi);
		min_len = lo;
		max_len = hi;
	endfunction

	// clamp, then x = round((L - 0.25 m) * 10 / 3) in Q1.15, saturated
	function longint clamp_normalize(bit [15:0] len);
		longint l;
		longint num;
		longint q;
		l = len;
		if (l < min_len) l = min_len;
		if (l > max_len) l = max_len;
		num = (l - 16384) * 10;
		if (num >= 0) q = (num + 1) / 3;
		else q = -((-num + 1) / 3);
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q;
	endfunction

	function bit signed [24:0] horner_cubic(int row, int col, longint x);
		longint acc;
		longint prod;
		acc = GAIN_COEF[row][col][0];
		for (int k = 1; k < 4; k++) begin
			prod = acc * x + 16384;
			acc = (prod >>> 15) + longint'(GAIN_COEF[row][col][k]);
		end
		if (acc > 16777215) acc = 16777215;
		if (acc < -16777216) acc = -16777216;
		return acc[24:0];
	endfunction

	function void note_leg_request(bit [15:0] len);
		longint      x;
		gain_entry_t e;
		x = clamp_normalize(len);
		requests++;
		for (int r = 0; r < 2; r++) begin
			for (int c = 0; c < 6; c++) begin
				e.actuator = r[0];
				e.state_col = c[2:0];
				e.gain = horner_cubic(r, c, x);
				e.last = (r == 1 && c == 5);
				pending_gains.push_back(e);
			end
		end
	endfunction

	task report_mismatch(string what);
		$display("[%0t] MISMATCH after %0d gains: %s", $time, gains_seen, what);
		mismatches++;
	endtask

	task check_gain(logic act, logic [2:0] col, logic signed [24:0] gain, logic last);
		gain_entry_t e;
		if (pending_gains.size() == 0) begin
			report_mismatch($sformatf("unexpected gain act=%0d col=%0d val=%0d",
				act, col, gain));
		end else begin
			e = pending_gains.pop_front();
			if (act !== e.actuator)
				report_mismatch($sformatf("actuator_index %0d, want %0d", act, e.actuator));
			if (col !== e.state_col)
				report_mismatch($sformatf("state_index %0d, want %0d", col, e.state_col));
			if (gain !== e.gain)
				report_mismatch($sformatf("gain_value %0d, want %0d (act %0d col %0d)",
					gain, e.gain, e.actuator, e.state_col));
			if (last !== e.last)
				report_mismatch($sformatf("last_gain %0d, want %0d", last, e.last));
		end
		gains_seen++;
	endtask
endclass

module lqr_gain_polynomial_schedule_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lgps_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT = 400000;

	logic     clk;
	logic     arst_n;
	logic     cfg_we;
	cfg_idx_t cfg_index;
	logic [15:0] cfg_data;

	lgps_in_if  in_ch();
	lgps_out_if out_ch();

	gain_schedule_checker checker_h;
	bit tx_idle;
	bit rx_idle;
	int rx_hold;
	int cycles;
	int phases;

	lqr_gain_polynomial_schedule u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			checker_h.check_gain(out_ch.actuator_index, out_ch.state_index,
				out_ch.gain_value, out_ch.last_gain);
			rx_hold = rx_idle ? $urandom_range(0, 6) : 0;
		end
	end

	initial begin
		rx_hold = 0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				out_ch.ready <= 1'b0;
				rx_hold--;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic write_limits(logic [15:0] lo, logic [15:0] hi);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MIN_LEG;
		cfg_data <= lo;
		@(negedge clk);
		cfg_index <= CFG_MAX_LEG;
		cfg_data <= hi;
		@(negedge clk);
		cfg_we <= 1'b0;
		checker_h.set_limits(lo, hi);
		phases++;
	endtask

	task automatic send_leg(logic [15:0] len);
		int gap;
		gap = tx_idle ? $urandom_range(0, 6) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.len_sample <= len;
		do @(posedge clk); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
		checker_h.note_leg_request(len);
	endtask

	// stop requesting and let every outstanding gain come back
	task automatic drain_gains();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (checker_h.pending_gains.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic pick_limits(int kind);
		logic [15:0] a;
		logic [15:0] b;
		a = $urandom_range(0, 65535);
		b = $urandom_range(0, 65535);
		case (kind)
			0: write_limits(MIN_LEG_RST, MAX_LEG_RST);
			1: write_limits(16'd0, 16'hffff);
			2: write_limits((a < b) ? a : b, (a < b) ? b : a);
			3: write_limits((a > b) ? a : b, (a > b) ? b : a);
			default: begin
				a = $urandom_range(14000, 16384);
				write_limits(a, a + 16'($urandom_range(0, 6000)));
			end
		endcase
	endtask

	function automatic logic [15:0] random_leg();
		int lo;
		int hi;
		int r;
		int v;
		lo = (checker_h.min_len < checker_h.max_len) ? checker_h.min_len : checker_h.max_len;
		hi = (checker_h.min_len < checker_h.max_len) ? checker_h.max_len : checker_h.min_len;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			v = $urandom_range(hi, lo);
		end else if (r < 85) begin
			v = $urandom_range(0, 65535);
		end else begin
			v = ((r % 2) ? checker_h.min_len : checker_h.max_len) + $urandom_range(0, 6) - 3;
			if (v < 0) v = 0;
			if (v > 65535) v = 65535;
		end
		return v[15:0];
	endfunction

	localparam int RANDOM_KIND [8] = '{0, 1, 2, 3, 4, 2, 4, 2};

	initial begin
		cycles = 0;
		phases = 0;
		checker_h = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MIN_LEG;
		cfg_data = 16'd0;
		in_ch.valid = 1'b0;
		in_ch.len_sample = 16'd0;
		out_ch.ready = 1'b0;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset limits, clamp edges and the center point
		send_leg(16'd9918);
		send_leg(16'd19888);
		send_leg(16'd16384);
		send_leg(16'd0);
		send_leg(16'hffff);
		send_leg(16'd9917);
		send_leg(16'd19889);
		send_leg(16'd12000);
		drain_gains();

		// full range: x saturates beyond the Q1.15 limits
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		write_limits(16'd0, 16'hffff);
		send_leg(16'd0);
		send_leg(16'hffff);
		send_leg(16'd16384);
		send_leg(16'd1);
		send_leg(16'd16385);
		send_leg(16'd26214);
		send_leg(16'd26215);
		send_leg(16'd6554);
		send_leg(16'd6553);
		drain_gains();

		// crossed limits resolve to max
		rx_idle = 1'b0;
		write_limits(16'd40000, 16'd12000);
		send_leg(16'd0);
		send_leg(16'hffff);
		send_leg(16'd20000);
		drain_gains();

		tx_idle = 1'b0;
		rx_idle = 1'b1;
		write_limits(16'd0, 16'd0);
		send_leg(16'd30000);
		send_leg(16'd0);
		drain_gains();

		for (int p = 0; p < 8; p++) begin
			tx_idle = (p % 3 != 1);
			rx_idle = (p % 4 != 2);
			pick_limits(RANDOM_KIND[p]);
			for (int n = 0; n < 45; n++) begin
				if (p == 3 && n == 20) drain_gains();
				send_leg(random_leg());
			end
			drain_gains();
		end

		$display("Ran %0d leg-length requests over %0d limit settings; %0d gains compared",
			checker_h.requests, phases, checker_h.gains_seen);
		if (checker_h.mismatches == 0 && checker_h.pending_gains.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
